FILE: src/mesh_single_use_vertex_counter_macros.svh
// ----------------------------------------------------------------------------
// mesh_single_use_vertex_counter_macros
// Assertion macros for the single-use vertex counter. They expand to
// concurrent assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MESH_SINGLE_USE_VERTEX_COUNTER_MACROS_SVH
`define MESH_SINGLE_USE_VERTEX_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define MSUVC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("msuvc assertion failed");

// Next-cycle implication, disabled during reset
`define MSUVC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("msuvc assertion failed");

`else

`define MSUVC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MSUVC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: src/msuvc_pkg.sv
// ----------------------------------------------------------------------------
// msuvc_pkg
// Shared widths, hash constants and the request types passed between the
// hash front end, the request queue and the probe back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msuvc_pkg;

    // Stream field widths
    localparam int FIELD_W     = 32;
    localparam int NUM_COORDS  = 9;
    localparam int IN_TDATA_W  = NUM_COORDS * FIELD_W;
    localparam int TALLY_W     = 11;
    localparam int OUT_TDATA_W = ((TALLY_W + 7) / 8) * 8;
    localparam int EXTRA_W     = 8;

    // Table geometry; the depth is a power of two so the hash reduces to a mask
    localparam int COORD_WIDTH = 32;
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 3 * COORD_WIDTH;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // Vertex hash: three rounds of xor, multiply and xor-shift
    localparam int HASH_W     = 64;
    localparam int HASH_SHIFT = 29;
    localparam logic [HASH_W-1:0] HASH_INIT = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [HASH_W-1:0] HASH_MUL  = 64'hFF51_AFD7_ED55_8CCD;

    // Request queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One vertex insert request
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] start;
        logic             last;
    } t_vtx_req;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: src/mesh_single_use_vertex_counter.sv
// ----------------------------------------------------------------------------
// mesh_single_use_vertex_counter
// Counts the vertices of a triangle mesh that occur exactly once, using a
// bounded hash table with linear probing and a saturating occurrence mark.
// ----------------------------------------------------------------------------
// One triangle is taken per transfer. The hash front end hashes its three
// vertices one after another, each in three multiply-and-fold rounds, and
// pushes one queue request per vertex before it takes the next triangle.
// The probe back end reads and then checks one slot per probe, moving on
// to the next slot on a collision; a four-entry queue lets it trail the
// front end. The request with tlast set yields one result: the single-use
// count plus the offset register, saturated at 2047, with tuser flagging a
// vertex dropped on a full table. After reset, and after each result, a
// clearing pass over all 1024 slots empties the occurrence marks; no triangle
// is accepted meanwhile. Write the offset only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_single_use_vertex_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: extra_count offset
    input  logic                               i_cfg_we,
    input  logic [msuvc_pkg::EXTRA_W-1:0]      i_cfg_wdata,
    // Triangle input
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each, from bit 0)
    input  logic [msuvc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // Result output
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // single_use_count [10:0], zero fill above
    output logic [msuvc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // table_overflow [0]
    output logic [0:0]                         o_m_axis_tuser
);

    msuvc_pkg::t_vtx_req             w_push_req;
    msuvc_pkg::t_vtx_req             w_head;
    msuvc_pkg::t_q_stat              w_q_stat;
    logic                            w_push;
    logic                            w_pop;
    logic                            w_clear_busy;
    logic [msuvc_pkg::TALLY_W-1:0]   w_count;
    logic                            w_overflow;

    msuvc_hash_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_clear_busy (w_clear_busy),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_req        (w_push_req)
    );

    msuvc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_req (w_push_req),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_q_stat)
    );

    msuvc_probe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head       (w_head),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_clear_busy (w_clear_busy),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_count    (w_count),
        .o_m_overflow (w_overflow)
    );

    // Pack the result fields
    assign o_m_axis_tdata = msuvc_pkg::OUT_TDATA_W'(w_count);
    assign o_m_axis_tuser = w_overflow;

endmodule

FILE: src/msuvc_hash_front.sv
// ----------------------------------------------------------------------------
// msuvc_hash_front
// Accepts a triangle, hashes its three vertices one after another with a
// split 64-bit multiply, and pushes one insert request per vertex.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msuvc_hash_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [msuvc_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                               i_s_tlast,
    input  logic                               i_clear_busy,
    input  msuvc_pkg::t_q_stat                 i_q_stat,
    output logic                               o_push,
    output msuvc_pkg::t_vtx_req                o_req
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MIX,
        F_PUSH
    } t_fstate;

    localparam logic [1:0] LAST_ROUND  = 2'd2;
    localparam logic [1:0] LAST_VERTEX = 2'd2;

    t_fstate                                r_state;
    logic [msuvc_pkg::COORD_WIDTH-1:0]      r_coord [msuvc_pkg::NUM_COORDS];
    logic                                   r_last;
    logic [1:0]                             r_vtx;
    logic [1:0]                             r_round;
    logic [msuvc_pkg::HASH_W-1:0]           r_h;
    logic [msuvc_pkg::HASH_W-1:0]           r_p0;
    logic [31:0]                            r_p1;
    logic [31:0]                            r_p2;

    logic [3:0]                             w_word_sel;
    logic [msuvc_pkg::HASH_W-1:0]           w_x;
    logic [msuvc_pkg::HASH_W-1:0]           w_p0;
    logic [31:0]                            w_p1;
    logic [31:0]                            w_p2;
    logic [msuvc_pkg::HASH_W-1:0]           w_m;
    logic [msuvc_pkg::HASH_W-1:0]           w_hn;

    // Current vertex always sits in the three lowest words
    assign w_word_sel = {2'b00, r_round};
    assign w_x = r_h ^ msuvc_pkg::HASH_W'(r_coord[w_word_sel]);

    // Partial products of the 64-bit multiply modulo 2^64
    assign w_p0 = msuvc_pkg::HASH_W'(w_x[31:0]) * msuvc_pkg::HASH_W'(msuvc_pkg::HASH_MUL[31:0]);
    assign w_p1 = w_x[31:0] * msuvc_pkg::HASH_MUL[63:32];
    assign w_p2 = w_x[63:32] * msuvc_pkg::HASH_MUL[31:0];

    // Combine partial products and fold
    assign w_m  = r_p0 + {r_p1 + r_p2, 32'h0};
    assign w_hn = w_m ^ (w_m >> msuvc_pkg::HASH_SHIFT);

    // Handshakes and request payload
    assign o_s_tready = (r_state == F_IDLE) && !i_clear_busy;
    assign o_push     = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_req.key   = {r_coord[2], r_coord[1], r_coord[0]};
    assign o_req.start = r_h[msuvc_pkg::IDX_W-1:0];
    assign o_req.last  = r_last && (r_vtx == LAST_VERTEX);

    // Sequence the rounds and vertices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_vtx   <= '0;
            r_round <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        for (int i = 0; i < msuvc_pkg::NUM_COORDS; i++) begin
                            r_coord[i] <= msuvc_pkg::COORD_WIDTH'(
                                i_s_tdata[i*msuvc_pkg::FIELD_W +: msuvc_pkg::FIELD_W]);
                        end
                        r_last  <= i_s_tlast;
                        r_vtx   <= '0;
                        r_round <= '0;
                        r_h     <= msuvc_pkg::HASH_INIT;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_p0    <= w_p0;
                    r_p1    <= w_p1;
                    r_p2    <= w_p2;
                    r_state <= F_MIX;
                end
                F_MIX: begin
                    r_h <= w_hn;
                    if (r_round == LAST_ROUND) begin
                        r_round <= '0;
                        r_state <= F_PUSH;
                    end else begin
                        r_round <= r_round + 2'd1;
                        r_state <= F_MUL;
                    end
                end
                F_PUSH: begin
                    if (!i_q_stat.full) begin
                        if (r_vtx == LAST_VERTEX) begin
                            r_state <= F_IDLE;
                        end else begin
                            // Shift the next vertex into the low words
                            for (int i = 0; i < msuvc_pkg::NUM_COORDS - 3; i++) begin
                                r_coord[i] <= r_coord[i+3];
                            end
                            r_vtx   <= r_vtx + 2'd1;
                            r_h     <= msuvc_pkg::HASH_INIT;
                            r_state <= F_MUL;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: src/msuvc_queue.sv
// ----------------------------------------------------------------------------
// msuvc_queue
// Small first-in first-out buffer of vertex insert requests between the
// hash front end and the probe back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msuvc_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  msuvc_pkg::t_vtx_req    i_push_req,
    input  logic                   i_pop,
    output msuvc_pkg::t_vtx_req    o_head,
    output msuvc_pkg::t_q_stat     o_stat
);

    msuvc_pkg::t_vtx_req              r_mem [msuvc_pkg::QUEUE_DEPTH];
    logic [msuvc_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [msuvc_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [msuvc_pkg::QPTR_W:0]       r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (msuvc_pkg::QPTR_W + 1)'(msuvc_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/msuvc_probe_back.sv
// ----------------------------------------------------------------------------
// msuvc_probe_back
// Runs each insert request against the hash table with linear probing,
// keeps the single-use tally, emits the result on the last triangle and
// sweeps the occurrence marks back to empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "mesh_single_use_vertex_counter_macros.svh"

module msuvc_probe_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [msuvc_pkg::EXTRA_W-1:0]      i_cfg_wdata,
    input  msuvc_pkg::t_vtx_req                i_head,
    input  msuvc_pkg::t_q_stat                 i_q_stat,
    output logic                               o_pop,
    output logic                               o_clear_busy,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [msuvc_pkg::TALLY_W-1:0]      o_m_count,
    output logic                               o_m_overflow
);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_EMIT
    } t_bstate;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_ONCE  = 2'd1;
    localparam logic [1:0] MARK_MANY  = 2'd2;
    localparam logic [msuvc_pkg::IDX_W-1:0] LAST_IDX =
        msuvc_pkg::IDX_W'(msuvc_pkg::TABLE_DEPTH - 1);

    // Table memories
    logic [1:0]                       r_mark_mem [msuvc_pkg::TABLE_DEPTH];
    logic [msuvc_pkg::KEY_W-1:0]      r_key_mem  [msuvc_pkg::TABLE_DEPTH];

    t_bstate                          r_state;
    logic [msuvc_pkg::IDX_W-1:0]      r_clr_idx;
    msuvc_pkg::t_vtx_req              r_req;
    logic [msuvc_pkg::IDX_W-1:0]      r_slot;
    logic [msuvc_pkg::IDX_W-1:0]      r_probe;
    logic [msuvc_pkg::TALLY_W-1:0]    r_tally;
    logic                             r_overflow;
    logic [msuvc_pkg::EXTRA_W-1:0]    r_extra;
    logic                             r_out_valid;
    logic [msuvc_pkg::TALLY_W-1:0]    r_out_count;
    logic                             r_out_ovf;
    logic [1:0]                       r_rd_mark;
    logic [msuvc_pkg::KEY_W-1:0]      r_rd_key;

    logic                             w_check;
    logic                             w_empty;
    logic                             w_hit;
    logic                             w_advance;
    logic                             w_mark_we;
    logic [msuvc_pkg::IDX_W-1:0]      w_mark_addr;
    logic [1:0]                       w_mark_wdata;
    logic                             w_key_we;
    logic                             w_emit_go;
    logic [msuvc_pkg::TALLY_W:0]      w_sum;
    logic [msuvc_pkg::TALLY_W-1:0]    w_sum_sat;

    // Classify the probed slot
    assign w_check   = (r_state == B_CHECK);
    assign w_empty   = (r_rd_mark == MARK_EMPTY);
    assign w_hit     = !w_empty && (r_rd_key == r_req.key);
    assign w_advance = w_check && !w_empty && !w_hit && (r_probe != LAST_IDX);

    // Mark and key write ports
    assign w_key_we     = w_check && w_empty;
    assign w_mark_we    = (r_state == B_CLEAR) || w_key_we ||
                          (w_check && w_hit && (r_rd_mark == MARK_ONCE));
    assign w_mark_addr  = (r_state == B_CLEAR) ? r_clr_idx : r_slot;
    assign w_mark_wdata = (r_state == B_CLEAR) ? MARK_EMPTY :
                          (w_empty ? MARK_ONCE : MARK_MANY);

    // Final count with saturation
    assign w_sum     = {1'b0, r_tally} + (msuvc_pkg::TALLY_W + 1)'(r_extra);
    assign w_sum_sat = (w_sum > {1'b0, msuvc_pkg::TALLY_MAX}) ? msuvc_pkg::TALLY_MAX
                                                              : w_sum[msuvc_pkg::TALLY_W-1:0];
    assign w_emit_go = (r_state == B_EMIT) && (!r_out_valid || i_m_tready);

    assign o_pop        = (r_state == B_IDLE) && !i_q_stat.empty;
    assign o_clear_busy = (r_state == B_CLEAR);
    assign o_m_tvalid   = r_out_valid;
    assign o_m_count    = r_out_count;
    assign o_m_overflow = r_out_ovf;

    // Occurrence marks
    always_ff @(posedge i_clk) begin
        if (w_mark_we) begin
            r_mark_mem[w_mark_addr] <= w_mark_wdata;
        end
        r_rd_mark <= r_mark_mem[r_slot];
    end

    // Vertex keys
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[r_slot] <= r_req.key;
        end
        r_rd_key <= r_key_mem[r_slot];
    end

    // Offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extra <= '0;
        end else if (i_cfg_we) begin
            r_extra <= i_cfg_wdata;
        end
    end

    // Probe sequencer, tally and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_idx   <= '0;
            r_tally     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_emit_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_IDX) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_req   <= i_head;
                        r_slot  <= i_head.start;
                        r_probe <= '0;
                        r_state <= B_READ;
                    end
                end
                B_READ: begin
                    r_state <= B_CHECK;
                end
                B_CHECK: begin
                    if (w_advance) begin
                        r_slot  <= r_slot + 1'b1;
                        r_probe <= r_probe + 1'b1;
                        r_state <= B_READ;
                    end else begin
                        if (w_empty) begin
                            if (r_tally != msuvc_pkg::TALLY_MAX) begin
                                r_tally <= r_tally + 1'b1;
                            end
                        end else if (w_hit) begin
                            if (r_rd_mark == MARK_ONCE && r_tally != '0) begin
                                r_tally <= r_tally - 1'b1;
                            end
                        end else begin
                            // Table full: drop the vertex
                            r_overflow <= 1'b1;
                        end
                        r_state <= r_req.last ? B_EMIT : B_IDLE;
                    end
                end
                B_EMIT: begin
                    if (w_emit_go) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= w_sum_sat;
                        r_out_ovf   <= r_overflow;
                        r_tally     <= '0;
                        r_overflow  <= 1'b0;
                        r_clr_idx   <= '0;
                        r_state     <= B_CLEAR;
                    end
                end
                default: r_state <= B_CLEAR;
            endcase
        end
    end

    // A collision moves on to the next slot, wrapping around the table
    `MSUVC_ASSERT_NXT(a_probe_wraps, i_clk, i_rst_n, w_advance, (r_state == B_READ) && (r_slot == msuvc_pkg::IDX_W'($past(r_slot) + 1'b1)))

    // Overflow is only raised after the whole table was probed
    `MSUVC_ASSERT_IMP(a_overflow_cause, i_clk, i_rst_n, $rose(r_overflow), ($past(r_state) == B_CHECK) && ($past(r_probe) == LAST_IDX))

    // Emitting a result starts a fresh model with an empty tally
    `MSUVC_ASSERT_NXT(a_emit_clears, i_clk, i_rst_n, w_emit_go, r_out_valid && (r_tally == '0) && !r_overflow && (r_state == B_CLEAR))

endmodule

FILE: tb/mesh_single_use_vertex_counter_checker.sv
// ----------------------------------------------------------------------------
// mesh_single_use_vertex_counter_checker
// Watches the offset port and both streams of the single-use vertex counter.
// Keeps its own hash table of vertices, predicts the count that each mesh
// yields and compares it, field by field, with what the block sends out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_single_use_vertex_counter_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [msuvc_pkg::EXTRA_W-1:0]      i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    input  logic                               i_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each, from bit 0)
    input  logic [msuvc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    input  logic                               i_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // single_use_count [10:0], zero fill above
    input  logic [msuvc_pkg::OUT_TDATA_W-1:0]  i_m_axis_tdata,
    // table_overflow [0]
    input  logic [0:0]                         i_m_axis_tuser,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_counts_checked,
    output int                                 o_overflow_counts
);

    localparam int SLOTS   = msuvc_pkg::TABLE_DEPTH;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int FIELD_W = msuvc_pkg::FIELD_W;
    localparam int COORD_W = msuvc_pkg::COORD_WIDTH;
    localparam int KEY_W   = 3 * COORD_W;
    localparam int COUNT_W = msuvc_pkg::TALLY_W;

    localparam logic [63:0]        MIX_SEED   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0]        MIX_MULT   = 64'hFF51_AFD7_ED55_8CCD;
    localparam int                 MIX_SHIFT  = 29;
    localparam logic [COUNT_W-1:0] COUNT_CEIL = '1;

    // Occurrence state of one slot
    typedef enum logic [1:0] {
        MARK_EMPTY,
        MARK_ONCE,
        MARK_MANY
    } t_mark;

    // Count reported at the end of one mesh
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_mesh_count;

    logic [KEY_W-1:0]               slot_key  [SLOTS];
    t_mark                          slot_mark [SLOTS];
    logic [COUNT_W-1:0]             singles;
    logic                           dropped;
    logic [msuvc_pkg::EXTRA_W-1:0]  offset;
    t_mesh_count                    counts_due [$];
    int                             errors;
    int                             checked;
    int                             overflowed;

    // Home slot of a vertex: three rounds of xor, multiply and xor-shift
    function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
        logic [63:0] h;
        int          w;
        h = MIX_SEED;
        for (w = 0; w < 3; w++) begin
            h = h ^ 64'(key[w*COORD_W +: COORD_W]);
            h = h * MIX_MULT;
            h = h ^ (h >> MIX_SHIFT);
        end
        return h[SLOT_W-1:0];
    endfunction

    // Empty the table and drop the running tally
    task automatic wipe_table();
        int s;
        for (s = 0; s < SLOTS; s++) begin
            slot_mark[s] = MARK_EMPTY;
        end
        singles = '0;
        dropped = 1'b0;
    endtask

    // Insert one vertex with linear probing; flag a drop when no slot is free
    task automatic add_vertex(input logic [KEY_W-1:0] key);
        logic [SLOT_W-1:0] slot;
        int                probe;
        bit                placed;
        slot   = home_slot(key);
        placed = 1'b0;
        for (probe = 0; probe < SLOTS && !placed; probe++) begin
            if (slot_mark[slot] == MARK_EMPTY) begin
                slot_key[slot]  = key;
                slot_mark[slot] = MARK_ONCE;
                if (singles < COUNT_CEIL) singles = singles + 1'b1;
                placed = 1'b1;
            end else if (slot_key[slot] == key) begin
                if (slot_mark[slot] == MARK_ONCE) begin
                    slot_mark[slot] = MARK_MANY;
                    if (singles > 0) singles = singles - 1'b1;
                end
                placed = 1'b1;
            end else begin
                slot = slot + 1'b1;
            end
        end
        if (!placed) dropped = 1'b1;
    endtask

    // Follow offset writes and both streams at each clock edge
    always @(posedge i_clk) begin : watch
        t_mesh_count        due;
        t_mesh_count        seen;
        logic [COUNT_W:0]   sum;
        logic [KEY_W-1:0]   key;
        int                 v;
        int                 c;
        if (!i_rst_n) begin
            wipe_table();
            offset = '0;
            counts_due.delete();
        end else begin
            if (i_cfg_we) offset = i_cfg_wdata;

            // Insert the three vertices of an accepted triangle, close the mesh on tlast
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                for (v = 0; v < 3; v++) begin
                    for (c = 0; c < 3; c++) begin
                        key[c*COORD_W +: COORD_W] = i_s_axis_tdata[(v*3+c)*FIELD_W +: COORD_W];
                    end
                    add_vertex(key);
                end
                if (i_s_axis_tlast) begin
                    sum          = {1'b0, singles} + offset;
                    due.count    = (sum > COUNT_CEIL) ? COUNT_CEIL : sum[COUNT_W-1:0];
                    due.overflow = dropped;
                    counts_due.push_back(due);
                    wipe_table();
                end
            end

            // Compare an accepted count with the oldest one due
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen.count    = i_m_axis_tdata[COUNT_W-1:0];
                seen.overflow = i_m_axis_tuser[0];
                if (counts_due.size() == 0) begin
                    $display("%0t: count %0d (overflow %0b) arrived with none expected",
                             $time, seen.count, seen.overflow);
                    errors++;
                end else begin
                    due = counts_due.pop_front();
                    checked++;
                    if (due.overflow) overflowed++;
                    if (seen.count !== due.count) begin
                        $display("%0t: single-use count expected %0d, got %0d",
                                 $time, due.count, seen.count);
                        errors++;
                    end
                    if (seen.overflow !== due.overflow) begin
                        $display("%0t: overflow flag expected %0b, got %0b",
                                 $time, due.overflow, seen.overflow);
                        errors++;
                    end
                end
            end
        end
        o_fail_count      <= errors;
        o_pending         <= counts_due.size();
        o_counts_checked  <= checked;
        o_overflow_counts <= overflowed;
    end

endmodule

FILE: tb/mesh_single_use_vertex_counter_tb.sv
// ----------------------------------------------------------------------------
// mesh_single_use_vertex_counter_tb
// Feeds triangle meshes to the single-use vertex counter: a few hand-built
// meshes, random meshes that share vertices, and two meshes that overfill
// the vertex table. The offset register changes between meshes, the sender
// idles in bursts, the receiver stalls and once holds off for a long stretch.
// The checker beside the block predicts and compares every count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_single_use_vertex_counter_tb;

    localparam int VERT_W       = 3 * msuvc_pkg::FIELD_W;
    localparam int ITEM_GOAL    = 1400;
    localparam int FULL_TRIS    = 343;
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES  = 3000;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_MOSTLY
    } t_sink_mode;

    logic                               i_clk;
    logic                               i_rst_n         = 1'b0;
    logic                               i_cfg_we        = 1'b0;
    logic [msuvc_pkg::EXTRA_W-1:0]      i_cfg_wdata     = '0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    logic [msuvc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                               i_s_axis_tlast  = 1'b0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    logic [msuvc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [0:0]                         o_m_axis_tuser;

    int fail_count;
    int pending_counts;
    int counts_checked;
    int overflow_counts;

    int items_sent      = 0;
    int meshes_sent     = 0;
    int offsets_written = 0;
    int burst_left      = 0;
    bit hold_go         = 1'b0;

    mesh_single_use_vertex_counter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    mesh_single_use_vertex_counter_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_s_axis_tvalid   (i_s_axis_tvalid),
        .i_s_axis_tready   (o_s_axis_tready),
        .i_s_axis_tdata    (i_s_axis_tdata),
        .i_s_axis_tlast    (i_s_axis_tlast),
        .i_m_axis_tvalid   (o_m_axis_tvalid),
        .i_m_axis_tready   (i_m_axis_tready),
        .i_m_axis_tdata    (o_m_axis_tdata),
        .i_m_axis_tuser    (o_m_axis_tuser),
        .o_fail_count      (fail_count),
        .o_pending         (pending_counts),
        .o_counts_checked  (counts_checked),
        .o_overflow_counts (overflow_counts)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // End the run if the block hangs
    initial begin
        #20_000_000;
        $display("Timeout at %0t with %0d counts outstanding", $time, pending_counts);
        $display("TEST FAILED");
        $finish;
    end

    // Coordinate word, biased toward the extremes now and then
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 15));
            3:       return 32'h8000_0000 | 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VERT_W-1:0] fresh_vertex();
        return {pick_coord(), pick_coord(), pick_coord()};
    endfunction

    // Pack vertices a, b, c with a in the low bits
    function automatic logic [msuvc_pkg::IN_TDATA_W-1:0] pack_tri(
        input logic [VERT_W-1:0] a,
        input logic [VERT_W-1:0] b,
        input logic [VERT_W-1:0] c
    );
        return {c, b, a};
    endfunction

    // Offer one triangle request; idle between bursts, hold until accepted
    task automatic send_tri(input logic [msuvc_pkg::IN_TDATA_W-1:0] data, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (last) meshes_sent++;
    endtask

    // Drop valid, wait for every count to arrive, then let the clearing pass finish
    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_counts != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [msuvc_pkg::EXTRA_W-1:0] value);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        offsets_written++;
    endtask

    // Random mesh whose vertices are drawn again from its own pool
    task automatic run_mesh(input int n_tris, input int reuse_pct);
        logic [VERT_W-1:0] pool [$];
        logic [VERT_W-1:0] vert [3];
        int                t;
        int                v;
        for (t = 0; t < n_tris; t++) begin
            for (v = 0; v < 3; v++) begin
                if (pool.size() > 0 && $urandom_range(0, 99) < reuse_pct) begin
                    vert[v] = pool[$urandom_range(0, pool.size() - 1)];
                end else begin
                    vert[v] = fresh_vertex();
                    pool.push_back(vert[v]);
                end
            end
            send_tri(pack_tri(vert[0], vert[1], vert[2]), t == n_tris - 1);
        end
    endtask

    // Mesh of distinct vertices that overfills the table; optionally end on a
    // triangle that repeats the first vertex twice before one more new vertex
    task automatic run_full_table(input int n_tris, input bit repeat_tail);
        logic [VERT_W-1:0] vert [3];
        logic [VERT_W-1:0] first;
        int                serial;
        int                t;
        int                v;
        serial = 0;
        for (t = 0; t < n_tris; t++) begin
            for (v = 0; v < 3; v++) begin
                vert[v] = {$urandom, $urandom, 32'(serial)};
                serial++;
            end
            if (t == 0) first = vert[0];
            if (repeat_tail && t == n_tris - 1) begin
                vert[0] = first;
                vert[1] = first;
            end
            send_tri(pack_tri(vert[0], vert[1], vert[2]), t == n_tris - 1);
        end
    endtask

    // Result side: stall on a random pattern that is redrawn after each random span
    initial begin : result_sink
        t_sink_mode mode;
        int         span;
        int         k;
        bit         hold_done;
        hold_done = 1'b0;
        forever begin
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(32, 256);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                // Hold off once for a long stretch so the block backs up
                if (hold_go && !hold_done) begin
                    hold_done = 1'b1;
                    i_m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    SINK_OPEN:   i_m_axis_tready <= 1'b1;
                    SINK_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:     i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [VERT_W-1:0] strip [6];
        logic [VERT_W-1:0] zeros;
        logic [VERT_W-1:0] ones;
        logic [VERT_W-1:0] stripes;
        int                k;
        int                m;
        int                n_meshes;

        zeros   = '0;
        ones    = '1;
        stripes = {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All-zero vertex repeated inside one triangle around an all-ones vertex
        write_offset(8'd0);
        send_tri(pack_tri(zeros, ones, zeros), 1'b1);
        // One vertex three times: count stays at zero
        send_tri(pack_tri(stripes, stripes, stripes), 1'b1);
        // Strip of four triangles: end vertices once, inner ones two or three times
        for (k = 0; k < 6; k++) strip[k] = fresh_vertex();
        for (k = 0; k < 4; k++) begin
            send_tri(pack_tri(strip[k], strip[k+1], strip[k+2]), k == 3);
        end

        // Largest offset on three distinct vertices
        write_offset(8'hFF);
        send_tri(pack_tri({32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF},
                          {32'h0, 32'hFFFF_FFFF, 32'h0},
                          {32'd3, 32'd2, 32'd1}), 1'b1);
        // Overfilled table at the largest offset: every stored vertex single
        run_full_table(FULL_TRIS, 1'b0);

        // Small meshes while the receiver holds off
        write_offset(8'($urandom_range(0, 255)));
        hold_go <= 1'b1;
        for (m = 0; m < 5; m++) run_mesh($urandom_range(1, 3), 30);

        // Random phases, each under its own offset
        while (items_sent < ITEM_GOAL - FULL_TRIS) begin
            case ($urandom_range(0, 5))
                0:       write_offset(8'h00);
                1:       write_offset(8'hFF);
                default: write_offset(8'($urandom_range(0, 255)));
            endcase
            n_meshes = $urandom_range(2, 6);
            for (m = 0; m < n_meshes; m++) begin
                run_mesh(($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12),
                         $urandom_range(20, 70));
            end
        end

        // Overfilled table again, ending on repeats found through probing
        write_offset(8'h00);
        run_full_table(FULL_TRIS, 1'b1);

        quiesce();
        $display("Sent %0d triangles in %0d meshes under %0d offset settings.",
                 items_sent, meshes_sent, offsets_written);
        $display("Compared %0d counts, %0d of them from an overfilled table.",
                 counts_checked, overflow_counts);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
